### src/bc_pkg.sv
// Shared constants for the barycentric weight pipeline.
// No dependencies; used by bc_round and barycentric_coords.
package bc_pkg;
	// Integer bits of a weight, sign included (Q3.F).
	localparam int WEIGHT_INT_BITS = 4;
endpackage

### src/barycentric_coords.sv
// Top level of the barycentric weight pipeline.
// Depends on bc_pkg, bc_cell and bc_round.
//
// Usage: one transaction on the item channel (item_valid/item_ready) carries
// three triangle vertices and a query point in signed Q12.4. For each item
// one transaction on the result channel (result_valid/result_ready) returns
// three weights in signed Q3.WEIGHT_FRAC_BITS, rounded to nearest with ties
// away from zero and saturated, plus a degenerate flag (zero area, weights
// zero) and a saturated flag (some weight was clipped).
// Throughput is one item per cycle while the receiver keeps result_ready high.
// From acceptance to result_valid an item passes one stage of edge multipliers, one of
// edge subtraction, one of magnitude and overflow detection, a row of
// WEIGHT_FRAC_BITS + 5 divider cells that each resolve one quotient bit for
// all three weights, and the output register. The divider row sets the
// latency; the pipeline sets the one-per-cycle rate.
// Every stage holds its own valid bit. When the receiver stalls, results
// pile up towards the output and bubbles are squeezed out, so items are
// still taken until every stage is full; item_ready drops only then.
// Reset clears the valid bits; no transaction is in flight afterwards.
module barycentric_coords #(
	parameter int COORD_WIDTH      = 16,
	parameter int WEIGHT_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [COORD_WIDTH-1:0] vertex0_x,
	input  logic signed [COORD_WIDTH-1:0] vertex0_y,
	input  logic signed [COORD_WIDTH-1:0] vertex1_x,
	input  logic signed [COORD_WIDTH-1:0] vertex1_y,
	input  logic signed [COORD_WIDTH-1:0] vertex2_x,
	input  logic signed [COORD_WIDTH-1:0] vertex2_y,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [WEIGHT_FRAC_BITS+bc_pkg::WEIGHT_INT_BITS-1:0] weight0,
	output logic signed [WEIGHT_FRAC_BITS+bc_pkg::WEIGHT_INT_BITS-1:0] weight1,
	output logic signed [WEIGHT_FRAC_BITS+bc_pkg::WEIGHT_INT_BITS-1:0] weight2,
	output logic                          degenerate,
	output logic                          saturated
);
	localparam int CW = COORD_WIDTH;
	localparam int F  = WEIGHT_FRAC_BITS;
	localparam int IB = bc_pkg::WEIGHT_INT_BITS;
	localparam int WW = F + IB;
	localparam int PW = 2 * CW + 2;                  // product width
	localparam int DW = 2 * CW + 3;                  // exact edge width
	localparam int EW = (DW > 64) ? 64 : DW;         // edges wrap at 64 bits
	localparam int RW = EW + IB;                     // remainder and divisor
	localparam int QW = F + IB + 1;                  // quotient incl. round bit
	localparam int NC = QW;                          // divider cells
	localparam int NS = NC + 4;                      // total stages

	// Stage valid bits and the ready chain.
	logic [NS-1:0] vld_q;
	logic [NS:0]   en;

	always_comb begin
		en[NS] = result_ready;
		for (int i = NS - 1; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= item_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign item_ready   = en[0];
	assign result_valid = vld_q[NS-1];

	// Edge k is e(a,b,p). Edges 0..2 give the weight numerators, edge 3 the
	// doubled area, which is the edge function of vertex 2 against (v0,v1).
	logic signed [CW-1:0] ax[4], ay[4], bx[4], by[4], qx[4], qy[4];

	always_comb begin
		ax[0] = vertex1_x; ay[0] = vertex1_y; bx[0] = vertex2_x; by[0] = vertex2_y;
		ax[1] = vertex2_x; ay[1] = vertex2_y; bx[1] = vertex0_x; by[1] = vertex0_y;
		ax[2] = vertex0_x; ay[2] = vertex0_y; bx[2] = vertex1_x; by[2] = vertex1_y;
		ax[3] = vertex0_x; ay[3] = vertex0_y; bx[3] = vertex1_x; by[3] = vertex1_y;
		for (int k = 0; k < 3; k++) begin
			qx[k] = point_x;
			qy[k] = point_y;
		end
		qx[3] = vertex2_x;
		qy[3] = vertex2_y;
	end

	// Stage 1: differences and the two products of each edge function.
	logic signed [PW-1:0] pa_s1[4], pb_s1[4];
	// Stage 2: edge values.
	logic [EW-1:0]        edge_s2[4];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (en[0]) begin
				pa_s1[k] <= PW'(($signed({bx[k][CW-1], bx[k]}) - $signed({ax[k][CW-1], ax[k]}))
					* ($signed({qy[k][CW-1], qy[k]}) - $signed({ay[k][CW-1], ay[k]})));
				pb_s1[k] <= PW'(($signed({by[k][CW-1], by[k]}) - $signed({ay[k][CW-1], ay[k]}))
					* ($signed({qx[k][CW-1], qx[k]}) - $signed({ax[k][CW-1], ax[k]})));
			end
			if (en[1]) begin
				edge_s2[k] <= EW'($signed({pa_s1[k][PW-1], pa_s1[k]})
					- $signed({pb_s1[k][PW-1], pb_s1[k]}));
			end
		end
	end

	// Stage 3: magnitudes, quotient signs and the overflow check. The divisor
	// is the area magnitude scaled by the integer weight range, so the cells
	// start with the remainder below it unless the weight is out of range.
	logic [EW-1:0] mag_c[4];
	logic [RW-1:0] rem_s3[3], div_s3;
	logic          neg_s3[3], ovf_s3[3];
	logic          deg_s3;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mag_c[k] = edge_s2[k][EW-1] ? -edge_s2[k] : edge_s2[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			div_s3 <= {mag_c[3], {IB{1'b0}}};
			deg_s3 <= (edge_s2[3] == '0);
			for (int k = 0; k < 3; k++) begin
				rem_s3[k] <= {{IB{1'b0}}, mag_c[k]};
				neg_s3[k] <= edge_s2[k][EW-1] ^ edge_s2[3][EW-1];
				ovf_s3[k] <= {{IB{1'b0}}, mag_c[k]} >= {mag_c[3], {IB{1'b0}}};
			end
		end
	end

	// The divider row: three lanes of NC cells, one quotient bit per cell.
	logic [RW-1:0] rem_c[3][NC], div_c[3][NC];
	logic [QW-1:0] quo_c[3][NC];
	logic          neg_c[3][NC], ovf_c[3][NC];
	logic          deg_c[NC];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		for (genvar c = 0; c < NC; c++) begin : g_cell
			if (c == 0) begin : g_head
				bc_cell #(.RW(RW), .QW(QW)) u_cell (
					.clk    (clk),
					.en     (en[3]),
					.rem_in (rem_s3[l]),
					.div_in (div_s3),
					.quo_in ('0),
					.neg_in (neg_s3[l]),
					.ovf_in (ovf_s3[l]),
					.rem_q  (rem_c[l][c]),
					.div_q  (div_c[l][c]),
					.quo_q  (quo_c[l][c]),
					.neg_q  (neg_c[l][c]),
					.ovf_q  (ovf_c[l][c])
				);
			end else begin : g_body
				bc_cell #(.RW(RW), .QW(QW)) u_cell (
					.clk    (clk),
					.en     (en[3+c]),
					.rem_in (rem_c[l][c-1]),
					.div_in (div_c[l][c-1]),
					.quo_in (quo_c[l][c-1]),
					.neg_in (neg_c[l][c-1]),
					.ovf_in (ovf_c[l][c-1]),
					.rem_q  (rem_c[l][c]),
					.div_q  (div_c[l][c]),
					.quo_q  (quo_c[l][c]),
					.neg_q  (neg_c[l][c]),
					.ovf_q  (ovf_c[l][c])
				);
			end
		end
	end

	// The degenerate flag rides along the row.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			deg_c[0] <= deg_s3;
		end
		for (int c = 1; c < NC; c++) begin
			if (en[3+c]) begin
				deg_c[c] <= deg_c[c-1];
			end
		end
	end

	// Output stage: rounding, saturation and the result register.
	logic [WW-1:0] w_c[3];
	logic          sat_c[3];

	for (genvar l = 0; l < 3; l++) begin : g_round
		bc_round #(.F(F), .QW(QW), .WW(WW)) u_round (
			.quo    (quo_c[l][NC-1]),
			.neg    (neg_c[l][NC-1]),
			.ovf    (ovf_c[l][NC-1]),
			.deg    (deg_c[NC-1]),
			.weight (w_c[l]),
			.sat    (sat_c[l])
		);
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			weight0    <= w_c[0];
			weight1    <= w_c[1];
			weight2    <= w_c[2];
			degenerate <= deg_c[NC-1];
			saturated  <= sat_c[0] || sat_c[1] || sat_c[2];
		end
	end

`ifndef SYNTHESIS
	// A degenerate triangle always reports zero weights and no clipping.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |->
			weight0 == '0 && weight1 == '0 && weight2 == '0 && !saturated)
		else $error("degenerate result with nonzero weights or saturation");

	// Items are refused only when every stage is full and the output stalls.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready && (&vld_q))
		else $error("item refused while the pipeline has room");

	// An accepted item leaves the first stage valid.
	a_first_stage: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> vld_q[0])
		else $error("accepted item lost at the first stage");
`endif
endmodule

### src/bc_cell.sv
// One cell of the restoring divider row: produces one quotient bit per stage.
// No dependencies.
module bc_cell #(
	parameter int RW = 68,
	parameter int QW = 19
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] rem_in,
	input  logic [RW-1:0] div_in,
	input  logic [QW-1:0] quo_in,
	input  logic          neg_in,
	input  logic          ovf_in,
	output logic [RW-1:0] rem_q,
	output logic [RW-1:0] div_q,
	output logic [QW-1:0] quo_q,
	output logic          neg_q,
	output logic          ovf_q
);
	logic [RW-1:0] shifted;
	logic          take;

	// Unless the overflow flag is set, the remainder stays below the divisor, so the doubled value fits.
	assign shifted = {rem_in[RW-2:0], 1'b0};
	assign take    = shifted >= div_in;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= take ? shifted - div_in : shifted;
			div_q <= div_in;
			quo_q <= {quo_in[QW-2:0], take};
			neg_q <= neg_in;
			ovf_q <= ovf_in;
		end
	end
endmodule

### src/bc_round.sv
// Rounding and saturation of one weight from the divider quotient; a degenerate triangle gives zero.
// Depends on bc_pkg.
module bc_round #(
	parameter int F  = 14,
	parameter int QW = F + 5,
	parameter int WW = F + bc_pkg::WEIGHT_INT_BITS
) (
	input  logic [QW-1:0] quo,
	input  logic          neg,
	input  logic          ovf,
	input  logic          deg,
	output logic [WW-1:0] weight,
	output logic          sat
);
	localparam logic [QW-1:0] NEG_MAX = QW'(1) << (WW - 1);
	localparam logic [QW-1:0] POS_MAX = NEG_MAX - QW'(1);

	logic [QW:0]   sum;
	logic [QW-1:0] mag, lim, clipped;
	logic          clip;

	always_comb begin
		sum     = {1'b0, quo} + {{QW{1'b0}}, 1'b1};
		mag     = sum[QW:1];
		lim     = neg ? NEG_MAX : POS_MAX;
		clip    = ovf || (mag > lim);
		clipped = clip ? lim : mag;
		if (deg) begin
			weight = '0;
			sat    = 1'b0;
		end else begin
			weight = neg ? WW'(-clipped) : clipped[WW-1:0];
			sat    = clip;
		end
	end
endmodule
